/* rtl/iprtc_pkg.sv */
package iprtc_pkg;

    localparam int MAX_RULES   = 16;
    localparam int SLOT_W      = $clog2(MAX_RULES);
    localparam int CNT_W       = 64;
    localparam int NUM_CLASSES = 3;
    localparam int CLASS_W     = 2;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_DUMP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXISTS    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [7:0] REC_ALL   = 8'd1;
    localparam logic [7:0] REC_TCP   = 8'd2;
    localparam logic [7:0] REC_UDP   = 8'd3;
    localparam logic [7:0] REC_OTHER = 8'd4;
    localparam logic [7:0] REC_RULE  = 8'hFF;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [CLASS_W-1:0] CLS_TCP   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_UDP   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_OTHER = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] frame_len;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [31:0] stamp;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  record_type;
        logic [31:0] record_time;
        logic [63:0] pkt_delta;
        logic [63:0] byte_delta;
        logic [31:0] rec_low;
        logic [31:0] rec_high;
        logic        last;
    } out_item_t;

    // operation broadcast along the chain for one cycle
    typedef struct packed {
        logic        pkt;
        logic        add;
        logic        del;
        logic        clear;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] frame_len;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } cell_op_t;

    // status passed cell to cell
    typedef struct packed {
        logic found;
        logic free_seen;
    } chain_t;

    typedef struct packed {
        logic             valid;
        logic [31:0]      low;
        logic [31:0]      high;
        logic [CNT_W-1:0] pkts;
        logic [CNT_W-1:0] bytes;
    } slot_view_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STATUS,
        S_GLOBAL,
        S_RULES
    } state_t;

endpackage

/* rtl/iprtc_cell.sv */
module iprtc_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iprtc_pkg::cell_op_t    op,
    input  logic                   dup,
    input  iprtc_pkg::chain_t      chain_in,
    output iprtc_pkg::chain_t      chain_out,
    output iprtc_pkg::slot_view_t  view
);

    logic                         valid_reg, valid_next;
    logic [31:0]                  low_reg, low_next;
    logic [31:0]                  high_reg, high_next;
    logic [iprtc_pkg::CNT_W-1:0]  pkts_reg, pkts_next;
    logic [iprtc_pkg::CNT_W-1:0]  bytes_reg, bytes_next;
    logic                         exact;
    logic                         hit;

    assign exact = valid_reg && low_reg == op.range_low && high_reg == op.range_high;
    assign hit   = valid_reg && ((low_reg <= op.src_addr && op.src_addr <= high_reg) ||
                                 (low_reg <= op.dst_addr && op.dst_addr <= high_reg));

    assign chain_out.found     = chain_in.found || exact;
    assign chain_out.free_seen = chain_in.free_seen || !valid_reg;

    always_comb begin
        valid_next = valid_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        pkts_next  = pkts_reg;
        bytes_next = bytes_reg;
        if (op.pkt && hit) begin
            pkts_next  = pkts_reg + iprtc_pkg::CNT_W'(1);
            bytes_next = bytes_reg + iprtc_pkg::CNT_W'(op.frame_len);
        end
        if (op.clear) begin
            pkts_next  = '0;
            bytes_next = '0;
        end
        // add takes the first free slot when no slot holds the same rule
        if (op.add && !valid_reg && !chain_in.free_seen && !dup) begin
            valid_next = 1'b1;
            low_next   = op.range_low;
            high_next  = op.range_high;
            pkts_next  = '0;
            bytes_next = '0;
        end
        if (op.del && exact && !chain_in.found) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        low_reg   <= low_next;
        high_reg  <= high_next;
        pkts_reg  <= pkts_next;
        bytes_reg <= bytes_next;
    end

    assign view.valid = valid_reg;
    assign view.low   = low_reg;
    assign view.high  = high_reg;
    assign view.pkts  = pkts_reg;
    assign view.bytes = bytes_reg;

endmodule

/* rtl/ip_range_traffic_counter.sv */
// ip range traffic counter
// s_ channel (s_valid/s_ready/s_data): one command beat of type in_item_t;
//   packet beats update the tcp/udp/other counters and every matching rule,
//   add and delete edit the rule table, dump reads out and clears counts.
// m_ channel (m_valid/m_ready/m_data): result beats of type out_item_t.
//   add and delete give one status beat; dump gives all, tcp, udp and
//   other records, then one record per valid rule in slot order; the
//   final beat of a command has last set. packets give no beat.
// the rules sit in a row of 16 cells that compare in parallel, so a
// packet is captured and then updated, and add or delete is captured,
// executed and then waits for the status beat to be taken. a dump is
// captured, snapshots and clears the counts, then gives its record beats
// as the rule records step through the slots one per cycle while m_ready allows.
// one command is in work at a time; s_ready is high only when idle.
// a stalled m_ready holds the result beat and the block waits with it.
// aresetn (synchronous, active low) empties the rule table and clears the
// class counters; no clearing pass is needed.
module ip_range_traffic_counter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  iprtc_pkg::in_item_t    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output iprtc_pkg::out_item_t   m_data
);

    localparam int N = iprtc_pkg::MAX_RULES;
    localparam int W = iprtc_pkg::CNT_W;

    iprtc_pkg::state_t    state_reg, state_next;
    iprtc_pkg::in_item_t  cmd_reg;
    logic [1:0]           gidx_reg, gidx_next;
    logic [1:0]           status_reg, status_next;
    logic [N-1:0]         dumped_reg, dumped_next;

    logic [W-1:0] cls_pkts_reg  [iprtc_pkg::NUM_CLASSES];
    logic [W-1:0] cls_bytes_reg [iprtc_pkg::NUM_CLASSES];

    iprtc_pkg::cell_op_t   op;
    iprtc_pkg::chain_t     chain [N+1];
    iprtc_pkg::slot_view_t view  [N];

    iprtc_pkg::out_item_t  out_reg, out_next;
    logic                  mval_reg, mval_next;
    logic [iprtc_pkg::CLASS_W-1:0] cls;
    logic                  exec;
    logic [W-1:0]          all_pkts, all_bytes;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            iprtc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .op       (op),
                .dup      (chain[N].found),
                .chain_in (chain[g]),
                .chain_out(chain[g+1]),
                .view     (view[g])
            );
        end
    endgenerate

    assign s_ready = state_reg == iprtc_pkg::S_IDLE;
    assign exec    = state_reg == iprtc_pkg::S_EXEC;
    assign m_valid = mval_reg;
    assign m_data  = out_reg;

    always_comb begin
        if (cmd_reg.proto == iprtc_pkg::PROTO_TCP) begin
            cls = iprtc_pkg::CLS_TCP;
        end else if (cmd_reg.proto == iprtc_pkg::PROTO_UDP) begin
            cls = iprtc_pkg::CLS_UDP;
        end else begin
            cls = iprtc_pkg::CLS_OTHER;
        end
    end

    always_comb begin
        op            = '0;
        op.src_addr   = cmd_reg.src_addr;
        op.dst_addr   = cmd_reg.dst_addr;
        op.frame_len  = cmd_reg.frame_len;
        op.range_low  = cmd_reg.range_low;
        op.range_high = cmd_reg.range_high;
        op.pkt        = exec && cmd_reg.cmd == iprtc_pkg::CMD_PACKET;
        op.add        = exec && cmd_reg.cmd == iprtc_pkg::CMD_ADD;
        op.del        = exec && cmd_reg.cmd == iprtc_pkg::CMD_DELETE;
        op.clear      = exec && cmd_reg.cmd == iprtc_pkg::CMD_DUMP;
    end

    assign all_pkts  = cls_pkts_reg[0] + cls_pkts_reg[1] + cls_pkts_reg[2];
    assign all_bytes = cls_bytes_reg[0] + cls_bytes_reg[1] + cls_bytes_reg[2];

    // snapshot registers for the dump, taken in exec as cells clear
    logic [W-1:0] snap_pkts_reg  [iprtc_pkg::NUM_CLASSES];
    logic [W-1:0] snap_bytes_reg [iprtc_pkg::NUM_CLASSES];
    logic [W-1:0] snap_all_p_reg, snap_all_b_reg;
    logic [W-1:0] rp_reg [N];
    logic [W-1:0] rb_reg [N];
    logic [31:0]  rl_reg [N];
    logic [31:0]  rh_reg [N];
    logic [N-1:0] rv_reg;

    always_ff @(posedge aclk) begin
        if (exec && cmd_reg.cmd == iprtc_pkg::CMD_DUMP) begin
            snap_all_p_reg <= all_pkts;
            snap_all_b_reg <= all_bytes;
            for (int c = 0; c < iprtc_pkg::NUM_CLASSES; c++) begin
                snap_pkts_reg[c]  <= cls_pkts_reg[c];
                snap_bytes_reg[c] <= cls_bytes_reg[c];
            end
            for (int i = 0; i < N; i++) begin
                rp_reg[i] <= view[i].pkts;
                rb_reg[i] <= view[i].bytes;
                rl_reg[i] <= view[i].low;
                rh_reg[i] <= view[i].high;
                rv_reg[i] <= view[i].valid;
            end
        end
    end

    logic [N-1:0] rrem;
    logic [iprtc_pkg::SLOT_W-1:0] rsel;
    logic rsel_ok, rmore;
    assign rrem = rv_reg & ~dumped_reg;
    always_comb begin
        rsel    = '0;
        rsel_ok = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (rrem[i]) begin
                rsel    = iprtc_pkg::SLOT_W'(i);
                rsel_ok = 1'b1;
            end
        end
    end
    always_comb begin
        logic [N-1:0] after;
        after = rrem;
        after[rsel] = 1'b0;
        rmore = |after;
    end

    logic can_load;
    assign can_load = !mval_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        gidx_next   = gidx_reg;
        status_next = status_reg;
        dumped_next = dumped_reg;
        case (state_reg)
            iprtc_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = iprtc_pkg::S_EXEC;
                end
            end
            iprtc_pkg::S_EXEC: begin
                gidx_next   = '0;
                dumped_next = '0;
                case (cmd_reg.cmd)
                    iprtc_pkg::CMD_PACKET: state_next = iprtc_pkg::S_IDLE;
                    iprtc_pkg::CMD_ADD: begin
                        state_next = iprtc_pkg::S_STATUS;
                        if (chain[N].found) begin
                            status_next = iprtc_pkg::ST_EXISTS;
                        end else if (!chain[N].free_seen) begin
                            status_next = iprtc_pkg::ST_FULL;
                        end else begin
                            status_next = iprtc_pkg::ST_OK;
                        end
                    end
                    iprtc_pkg::CMD_DELETE: begin
                        state_next  = iprtc_pkg::S_STATUS;
                        status_next = chain[N].found ? iprtc_pkg::ST_OK
                                                     : iprtc_pkg::ST_NOT_FOUND;
                    end
                    default: state_next = iprtc_pkg::S_GLOBAL;
                endcase
            end
            iprtc_pkg::S_STATUS: begin
                if (can_load) begin
                    state_next = iprtc_pkg::S_IDLE;
                end
            end
            iprtc_pkg::S_GLOBAL: begin
                if (can_load) begin
                    gidx_next = gidx_reg + 2'd1;
                    if (gidx_reg == 2'd3) begin
                        state_next = rsel_ok ? iprtc_pkg::S_RULES : iprtc_pkg::S_IDLE;
                    end
                end
            end
            iprtc_pkg::S_RULES: begin
                if (can_load) begin
                    dumped_next[rsel] = 1'b1;
                    if (!rmore) begin
                        state_next = iprtc_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = iprtc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_next  = out_reg;
        mval_next = mval_reg && !m_ready;
        case (state_reg)
            iprtc_pkg::S_STATUS: begin
                if (can_load) begin
                    out_next        = '0;
                    out_next.status = status_reg;
                    out_next.last   = 1'b1;
                    mval_next       = 1'b1;
                end
            end
            iprtc_pkg::S_GLOBAL: begin
                if (can_load) begin
                    out_next             = '0;
                    out_next.kind        = 1'b1;
                    out_next.record_time = cmd_reg.stamp;
                    out_next.last        = gidx_reg == 2'd3 && !rsel_ok;
                    mval_next            = 1'b1;
                    case (gidx_reg)
                        2'd0: begin
                            out_next.record_type = iprtc_pkg::REC_ALL;
                            out_next.pkt_delta   = snap_all_p_reg;
                            out_next.byte_delta  = snap_all_b_reg;
                        end
                        2'd1: begin
                            out_next.record_type = iprtc_pkg::REC_TCP;
                            out_next.pkt_delta   = snap_pkts_reg[0];
                            out_next.byte_delta  = snap_bytes_reg[0];
                        end
                        2'd2: begin
                            out_next.record_type = iprtc_pkg::REC_UDP;
                            out_next.pkt_delta   = snap_pkts_reg[1];
                            out_next.byte_delta  = snap_bytes_reg[1];
                        end
                        default: begin
                            out_next.record_type = iprtc_pkg::REC_OTHER;
                            out_next.pkt_delta   = snap_pkts_reg[2];
                            out_next.byte_delta  = snap_bytes_reg[2];
                        end
                    endcase
                end
            end
            iprtc_pkg::S_RULES: begin
                if (can_load) begin
                    out_next             = '0;
                    out_next.kind        = 1'b1;
                    out_next.record_type = iprtc_pkg::REC_RULE;
                    out_next.record_time = cmd_reg.stamp;
                    out_next.pkt_delta   = rp_reg[rsel];
                    out_next.byte_delta  = rb_reg[rsel];
                    out_next.rec_low     = rl_reg[rsel];
                    out_next.rec_high    = rh_reg[rsel];
                    out_next.last        = !rmore;
                    mval_next            = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= iprtc_pkg::S_IDLE;
            mval_reg   <= 1'b0;
            gidx_reg   <= '0;
            dumped_reg <= '0;
            status_reg <= iprtc_pkg::ST_OK;
            for (int c = 0; c < iprtc_pkg::NUM_CLASSES; c++) begin
                cls_pkts_reg[c]  <= '0;
                cls_bytes_reg[c] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mval_reg   <= mval_next;
            gidx_reg   <= gidx_next;
            dumped_reg <= dumped_next;
            status_reg <= status_next;
            if (exec && cmd_reg.cmd == iprtc_pkg::CMD_PACKET) begin
                cls_pkts_reg[cls]  <= cls_pkts_reg[cls] + W'(1);
                cls_bytes_reg[cls] <= cls_bytes_reg[cls] + W'(cmd_reg.frame_len);
            end
            if (exec && cmd_reg.cmd == iprtc_pkg::CMD_DUMP) begin
                for (int c = 0; c < iprtc_pkg::NUM_CLASSES; c++) begin
                    cls_pkts_reg[c]  <= '0;
                    cls_bytes_reg[c] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_valid && s_ready) begin
            cmd_reg <= s_data;
        end
    end

endmodule
